// ===== rtl/cptr_pkg.sv =====
// shared types and constants for the contact point table
`timescale 1ns / 1ps
package cptr_pkg;
	localparam int MAX_CONTACTS = 8;
	localparam int IDX_W = $clog2(MAX_CONTACTS + 1);
	localparam int CNT_W = 4;
	localparam logic [32:0] CLOSE_AXIS_LIMIT = 33'd13108;
	localparam logic [63:0] CLOSE_LIMIT = 64'd171798692;

	typedef enum logic [2:0] {
		CFG_A_X = 3'd0, CFG_A_Y = 3'd1, CFG_A_Z = 3'd2,
		CFG_B_X = 3'd3, CFG_B_Y = 3'd4, CFG_B_Z = 3'd5
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE, ST_SCAN, ST_DONE
	} state_t;

	typedef struct packed {
		logic signed [31:0] oax, oay, oaz, obx, oby, obz;
		logic signed [31:0] nx, ny, nz, pen;
	} entry_t;

	function automatic logic signed [31:0] sat_sub(logic signed [31:0] a,
		logic signed [31:0] b);
		logic signed [32:0] d;
		d = {a[31], a} - {b[31], b};
		if (d[32] != d[31])
			return d[32] ? 32'sh80000000 : 32'sh7fffffff;
		return d[31:0];
	endfunction
endpackage

// ===== rtl/cptr_cell.sv =====
// one table slot: loads a new item, else during a scan shifts in its right neighbour or the head
`timescale 1ns / 1ps
module cptr_cell (
	input  logic              clk,
	input  logic              shift,
	input  logic              load_new,
	input  cptr_pkg::entry_t  new_entry,
	input  cptr_pkg::entry_t  from_right,
	output cptr_pkg::entry_t  entry
);
	cptr_pkg::entry_t entry_q;

	always_ff @(posedge clk) begin
		if (load_new)
			entry_q <= new_entry;
		else if (shift)
			entry_q <= from_right;
	end

	assign entry = entry_q;
endmodule

// ===== rtl/cptr_close.sv =====
// per-axis limit and squared distance test of two a offsets, registered result
`timescale 1ns / 1ps
module cptr_close (
	input  logic              clk,
	input  logic signed [31:0] sx, sy, sz,
	input  logic signed [31:0] nx, ny, nz,
	output logic              close
);
	logic [32:0] dx, dy, dz;
	logic signed [32:0] tx, ty, tz;
	logic [15:0] mx, my, mz;
	logic [33:0] sum;
	logic close_q;

	always_comb begin
		tx = {sx[31], sx} - {nx[31], nx};
		ty = {sy[31], sy} - {ny[31], ny};
		tz = {sz[31], sz} - {nz[31], nz};
		dx = tx[32] ? 33'(-tx) : 33'(tx);
		dy = ty[32] ? 33'(-ty) : 33'(ty);
		dz = tz[32] ? 33'(-tz) : 33'(tz);
		mx = dx[15:0];
		my = dy[15:0];
		mz = dz[15:0];
		sum = 34'(32'(mx) * 32'(mx)) + 34'(32'(my) * 32'(my)) + 34'(32'(mz) * 32'(mz));
	end

	always_ff @(posedge clk)
		close_q <= (dx <= cptr_pkg::CLOSE_AXIS_LIMIT) && (dy <= cptr_pkg::CLOSE_AXIS_LIMIT)
			&& (dz <= cptr_pkg::CLOSE_AXIS_LIMIT) && (64'(sum) < cptr_pkg::CLOSE_LIMIT);

	assign close = close_q;
endmodule

// ===== rtl/contact_point_table_reduce.sv =====
// contact point table: rotates entries through a row of cells, head is compared
// channel | dir | handshake
// cfg     | in  | cfg_valid/cfg_ready, cfg_index, cfg_data
// in      | in  | in_valid/in_ready, req_type, point/normal/penetration fields
// out     | out | out_valid/out_ready, contact_count, was_added, removed_count, dropped_full
// a clear goes from the scan state straight to done; an add compares each stored
// entry in turn as it rotates past the head cell, with an evaluate and an act phase
// no clearing pass after reset; in_ready is low from acceptance until the
// result is taken, so a stalled output holds the block
`timescale 1ns / 1ps
module contact_point_table_reduce (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic signed [31:0] point_a_x, point_a_y, point_a_z,
	input  logic signed [31:0] point_b_x, point_b_y, point_b_z,
	input  logic signed [31:0] normal_x, normal_y, normal_z,
	input  logic signed [31:0] penetration,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  contact_count,
	output logic        was_added,
	output logic [3:0]  removed_count,
	output logic        dropped_full
);
	localparam int N = cptr_pkg::MAX_CONTACTS;
	localparam int IW = cptr_pkg::IDX_W;

	logic signed [31:0] pos_q [6];
	cptr_pkg::state_t state_q, state_d;
	cptr_pkg::entry_t new_q;
	cptr_pkg::entry_t cells [N];
	logic [IW-1:0] count_q, left_q, removed_q;
	logic keep_q, phase_q, added_q, full_q;
	logic shift, load_new, close;
	logic [N-1:0] load_vec;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 6; k++) pos_q[k] <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				cptr_pkg::CFG_A_X: pos_q[0] <= cfg_data;
				cptr_pkg::CFG_A_Y: pos_q[1] <= cfg_data;
				cptr_pkg::CFG_A_Z: pos_q[2] <= cfg_data;
				cptr_pkg::CFG_B_X: pos_q[3] <= cfg_data;
				cptr_pkg::CFG_B_Y: pos_q[4] <= cfg_data;
				cptr_pkg::CFG_B_Z: pos_q[5] <= cfg_data;
				default: ;
			endcase
		end
	end

	// entries sit in cells 0..count-1; scanning rotates cell 0 to cell count-1
	genvar g;
	generate
		for (g = 0; g < N; g++) begin : g_cell
			cptr_pkg::entry_t right;
			if (g == N - 1) begin : g_last
				assign right = cells[0];
			end else begin : g_mid
				assign right = (IW'(g) == count_q - 1'b1) ? cells[0] : cells[g + 1];
			end
			cptr_cell u_cell (
				.clk(clk), .shift(shift && (IW'(g) < count_q)),
				.load_new(load_vec[g]), .new_entry(new_q),
				.from_right(right), .entry(cells[g])
			);
		end
	endgenerate

	cptr_close u_close (
		.clk(clk), .sx(cells[0].oax), .sy(cells[0].oay), .sz(cells[0].oaz),
		.nx(new_q.oax), .ny(new_q.oay), .nz(new_q.oaz), .close(close)
	);

	// phase 0 evaluates head, phase 1 drops it or rotates it; a kept close head cancels the add
	logic drop_head;
	assign drop_head = close && ($signed(cells[0].pen) > $signed(new_q.pen));

	always_comb begin
		state_d = state_q;
		shift = 1'b0;
		load_new = 1'b0;
		in_ready = 1'b0;
		case (state_q)
			cptr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = cptr_pkg::ST_SCAN;
			end
			cptr_pkg::ST_SCAN: begin
				if (left_q == '0) begin
					load_new = keep_q && (count_q < IW'(N));
					state_d = cptr_pkg::ST_DONE;
				end else if (phase_q) begin
					shift = 1'b1;
				end
			end
			cptr_pkg::ST_DONE: if (out_ready) state_d = cptr_pkg::ST_IDLE;
			default: state_d = cptr_pkg::ST_IDLE;
		endcase
		for (int k = 0; k < N; k++) load_vec[k] = load_new && (count_q == IW'(k));
	end

	// dropping the head: rotate left so the head moves to cell count-1, then shrink the count past it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cptr_pkg::ST_IDLE;
			count_q <= '0;
			left_q <= '0;
			removed_q <= '0;
			keep_q <= 1'b0;
			phase_q <= 1'b0;
			added_q <= 1'b0;
			full_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				cptr_pkg::ST_IDLE: if (in_valid) begin
					removed_q <= '0;
					keep_q <= req_type;
					phase_q <= 1'b0;
					added_q <= 1'b0;
					full_q <= 1'b0;
					if (!req_type) begin
						count_q <= '0;
						left_q <= '0;
					end else begin
						left_q <= count_q;
					end
				end
				cptr_pkg::ST_SCAN: begin
					if (left_q == '0) begin
						if (load_new) begin
							count_q <= count_q + 1'b1;
							added_q <= 1'b1;
						end
						full_q <= keep_q && (count_q >= IW'(N));
					end else if (!phase_q) begin
						phase_q <= 1'b1;
					end else begin
						phase_q <= 1'b0;
						left_q <= left_q - 1'b1;
						if (close && !drop_head) keep_q <= 1'b0;
						if (drop_head) begin
							count_q <= count_q - 1'b1;
							removed_q <= removed_q + 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// new item: offsets from the configured positions, plus normal and penetration
	always_ff @(posedge clk) begin
		if (state_q == cptr_pkg::ST_IDLE && in_valid) begin
			new_q.oax <= cptr_pkg::sat_sub(point_a_x, pos_q[0]);
			new_q.oay <= cptr_pkg::sat_sub(point_a_y, pos_q[1]);
			new_q.oaz <= cptr_pkg::sat_sub(point_a_z, pos_q[2]);
			new_q.obx <= cptr_pkg::sat_sub(point_b_x, pos_q[3]);
			new_q.oby <= cptr_pkg::sat_sub(point_b_y, pos_q[4]);
			new_q.obz <= cptr_pkg::sat_sub(point_b_z, pos_q[5]);
			new_q.nx <= normal_x;
			new_q.ny <= normal_y;
			new_q.nz <= normal_z;
			new_q.pen <= penetration;
		end
	end

	assign out_valid = (state_q == cptr_pkg::ST_DONE);
	assign contact_count = 4'(count_q);
	assign was_added = added_q;
	assign removed_count = 4'(removed_q);
	assign dropped_full = full_q;
endmodule

// ===== rtl/cptr_checker.sv =====
// port level checks for the contact point table, bound to the top level
`timescale 1ns / 1ps
module cptr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [3:0] contact_count,
	input logic       was_added,
	input logic [3:0] removed_count,
	input logic       dropped_full
);
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(contact_count))
		else $error("result changed while stalled");
	a_one_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(was_added && dropped_full))
		else $error("added and dropped together");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken while result pending");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while busy");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> contact_count <= 4'd8 && removed_count <= 4'd8)
		else $error("count out of range");
endmodule

bind contact_point_table_reduce cptr_checker u_cptr_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .contact_count(contact_count),
	.was_added(was_added), .removed_count(removed_count), .dropped_full(dropped_full)
);
